// File: sv/dcs_pkg.sv
package dcs_pkg;

	localparam int MAX_POINTS_DEF = 256;
	localparam int TOL_W          = 16;
	localparam int TIE_W          = 9;
	localparam int ONE_Q14        = 16384;

	typedef struct packed {
		logic signed [31:0] depth;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic signed [15:0] norm_z;
		logic               last;
		logic               no_point;
	} pts_word_t;

	typedef struct packed {
		logic signed [31:0] best_depth;
		logic signed [31:0] out_pos_x;
		logic signed [31:0] out_pos_y;
		logic signed [31:0] out_pos_z;
		logic signed [15:0] out_norm_x;
		logic signed [15:0] out_norm_y;
		logic signed [15:0] out_norm_z;
		logic [TIE_W-1:0]   tie_count;
		logic               empty_error;
	} res_word_t;

endpackage

// File: sv/dcs_if.sv
interface dcs_pts_if;
	import dcs_pkg::*;
	logic      valid;
	logic      ready;
	pts_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface dcs_res_if;
	import dcs_pkg::*;
	logic      valid;
	logic      ready;
	res_word_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

// File: sv/deepest_contact_select_core.sv
// Channel   Direction  Word
// points    in         one contact point (or a closing word) per handshake
// result    out        one selection result per closed set
// tol_we    in         write of tie_tolerance, no handshake
//
// A point word is taken on its handshake. A closing word of an empty set
// gives an empty_error result without a pass; any other starts a finishing
// pass through one shared subtract-and-compare unit: three position divisions
// of NUMW quotient bits each (NUMW is 46 by default), three squaring steps, a
// square root and three normal divisions, or only the position divisions when
// no normalisation is needed. The result is offered in the cycle after the
// pass ends. The points channel is not ready during that pass or while a
// result waits. Reset clears the set state and sets tie_tolerance to one.
module deepest_contact_select_core #(
	parameter int MAX_POINTS = dcs_pkg::MAX_POINTS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tol_we,
	input  logic [dcs_pkg::TOL_W-1:0] tol_data,
	dcs_pts_if.sink                   points,
	dcs_res_if.source                 result
);
	import dcs_pkg::*;

	localparam int TIE_CAP = (MAX_POINTS < 511) ? MAX_POINTS : 511;
	localparam int CW      = $clog2(TIE_CAP + 1);
	localparam int PSW     = 32 + CW;
	localparam int NSW     = 16 + CW;
	localparam int NUMW    = (PSW + 1 > NSW + 21) ? PSW + 1 : NSW + 21;
	localparam int BW      = $clog2(NUMW + 1);
	localparam int RW      = 36;

	typedef enum logic [3:0] {
		S_IDLE, S_PLD, S_PDIV, S_SQ, S_SQA, S_RLD, S_ROOT, S_NLD, S_NDIV, S_OUT
	} state_t;

	state_t                 state_q;
	logic [TOL_W-1:0]       tol_q;
	logic signed [31:0]     best_q;
	logic signed [PSW-1:0]  psum_q [3];
	logic signed [NSW-1:0]  nsum_q [3];
	logic [CW-1:0]          cnt_q;
	logic                   seen_q;
	logic [1:0]             idx_q;
	logic [NUMW-1:0]        num_q;
	logic [NUMW-1:0]        quo_q;
	logic [RW-1:0]          rem_q;
	logic [31:0]            root_q;
	logic [63:0]            l2_q;
	logic [2*NSW-1:0]       prod_q;
	logic [BW-1:0]          bit_q;
	logic                   neg_q;
	res_word_t              res_q;

	pts_word_t              pw;
	logic signed [33:0]     d_up;
	logic signed [33:0]     d_dn;
	logic                   restart;
	logic                   tie;
	logic                   acc;
	logic [RW-1:0]          op_a;
	logic [RW-1:0]          op_b;
	logic [RW-1:0]          op_d;
	logic                   op_ge;
	logic [NUMW-1:0]        qf;
	logic signed [PSW-1:0]  ps_cur;
	logic signed [NSW-1:0]  ns_cur;
	logic [PSW-1:0]         ps_abs;
	logic [NSW-1:0]         ns_abs;
	logic [15:0]            nsat;
	logic                   nzero;

	assign pw           = points.data;
	assign acc          = points.valid && points.ready;
	assign points.ready = (state_q == S_IDLE);
	assign result.valid = (state_q == S_OUT);
	assign result.data  = res_q;

	assign d_up    = 34'(pw.depth) - 34'(best_q);
	assign d_dn    = 34'(best_q) - 34'(pw.depth);
	assign restart = !seen_q || (d_up > $signed({18'd0, tol_q}));
	assign tie     = (d_dn <= $signed({18'd0, tol_q}));

	assign ps_cur = psum_q[idx_q];
	assign ns_cur = nsum_q[idx_q];
	assign ps_abs = ps_cur[PSW-1] ? PSW'(-ps_cur) : PSW'(ps_cur);
	assign ns_abs = ns_cur[NSW-1] ? NSW'(-ns_cur) : NSW'(ns_cur);
	assign nzero  = (nsum_q[0] == '0) && (nsum_q[1] == '0) && (nsum_q[2] == '0);

	always_comb begin
		if (state_q == S_ROOT) begin
			op_a = {rem_q[RW-3:0], l2_q[63:62]};
			op_b = RW'({root_q, 2'b01});
		end else begin
			op_a = {rem_q[RW-2:0], num_q[NUMW-1]};
			op_b = (state_q == S_PDIV) ? RW'(cnt_q) : RW'(root_q);
		end
		op_ge = (op_a >= op_b);
		op_d  = op_a - op_b;
	end

	assign qf = {quo_q[NUMW-2:0], op_ge};

	always_comb begin
		if (!neg_q) begin
			nsat = (qf > NUMW'(32767)) ? 16'h7FFF : qf[15:0];
		end else begin
			nsat = (qf > NUMW'(32768)) ? 16'h8000 : 16'(-qf[15:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tol_q   <= TOL_W'(1);
			best_q  <= '0;
			for (int i = 0; i < 3; i++) begin
				psum_q[i] <= '0;
				nsum_q[i] <= '0;
			end
			cnt_q   <= '0;
			seen_q  <= 1'b0;
			idx_q   <= '0;
			num_q   <= '0;
			quo_q   <= '0;
			rem_q   <= '0;
			root_q  <= '0;
			l2_q    <= '0;
			prod_q  <= '0;
			bit_q   <= '0;
			neg_q   <= 1'b0;
			res_q   <= '0;
		end else begin
			if (tol_we) begin
				tol_q <= tol_data;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (!pw.no_point) begin
							if (restart) begin
								best_q    <= pw.depth;
								psum_q[0] <= PSW'(pw.pos_x);
								psum_q[1] <= PSW'(pw.pos_y);
								psum_q[2] <= PSW'(pw.pos_z);
								nsum_q[0] <= NSW'(pw.norm_x);
								nsum_q[1] <= NSW'(pw.norm_y);
								nsum_q[2] <= NSW'(pw.norm_z);
								cnt_q     <= CW'(1);
								seen_q    <= 1'b1;
							end else if (tie && (cnt_q < CW'(TIE_CAP))) begin
								psum_q[0] <= psum_q[0] + PSW'(pw.pos_x);
								psum_q[1] <= psum_q[1] + PSW'(pw.pos_y);
								psum_q[2] <= psum_q[2] + PSW'(pw.pos_z);
								nsum_q[0] <= nsum_q[0] + NSW'(pw.norm_x);
								nsum_q[1] <= nsum_q[1] + NSW'(pw.norm_y);
								nsum_q[2] <= nsum_q[2] + NSW'(pw.norm_z);
								cnt_q     <= cnt_q + CW'(1);
							end
						end
						if (pw.last) begin
							if (!seen_q && pw.no_point) begin
								res_q   <= {($bits(res_word_t) - 1)'(0), 1'b1};
								state_q <= S_OUT;
							end else begin
								idx_q   <= '0;
								state_q <= S_PLD;
							end
						end
					end
				end
				S_PLD: begin
					num_q   <= NUMW'(ps_abs) + NUMW'(cnt_q >> 1);
					neg_q   <= ps_cur[PSW-1];
					rem_q   <= '0;
					quo_q   <= '0;
					bit_q   <= BW'(NUMW);
					state_q <= S_PDIV;
				end
				S_PDIV: begin
					rem_q <= op_ge ? op_d : op_a;
					quo_q <= qf;
					num_q <= {num_q[NUMW-2:0], 1'b0};
					bit_q <= bit_q - BW'(1);
					if (bit_q == BW'(1)) begin
						case (idx_q)
							2'd0:    res_q.out_pos_x <= neg_q ? 32'(-qf) : 32'(qf);
							2'd1:    res_q.out_pos_y <= neg_q ? 32'(-qf) : 32'(qf);
							default: res_q.out_pos_z <= neg_q ? 32'(-qf) : 32'(qf);
						endcase
						if (idx_q != 2'd2) begin
							idx_q   <= idx_q + 2'd1;
							state_q <= S_PLD;
						end else begin
							res_q.best_depth  <= best_q;
							res_q.tie_count   <= TIE_W'(cnt_q);
							res_q.empty_error <= 1'b0;
							idx_q             <= '0;
							l2_q              <= '0;
							if (cnt_q <= CW'(1)) begin
								res_q.out_norm_x <= 16'(nsum_q[0]);
								res_q.out_norm_y <= 16'(nsum_q[1]);
								res_q.out_norm_z <= 16'(nsum_q[2]);
								state_q          <= S_OUT;
							end else if (nzero) begin
								res_q.out_norm_x <= 16'(ONE_Q14);
								res_q.out_norm_y <= '0;
								res_q.out_norm_z <= '0;
								state_q          <= S_OUT;
							end else begin
								state_q <= S_SQ;
							end
						end
					end
				end
				S_SQ: begin
					prod_q  <= (2*NSW)'(ns_cur * ns_cur);
					state_q <= S_SQA;
				end
				S_SQA: begin
					l2_q <= l2_q + 64'(prod_q);
					if (idx_q != 2'd2) begin
						idx_q   <= idx_q + 2'd1;
						state_q <= S_SQ;
					end else begin
						state_q <= S_RLD;
					end
				end
				S_RLD: begin
					l2_q    <= l2_q << 14;
					rem_q   <= '0;
					root_q  <= '0;
					bit_q   <= BW'(32);
					state_q <= S_ROOT;
				end
				S_ROOT: begin
					rem_q  <= op_ge ? op_d : op_a;
					root_q <= {root_q[30:0], op_ge};
					l2_q   <= l2_q << 2;
					bit_q  <= bit_q - BW'(1);
					if (bit_q == BW'(1)) begin
						idx_q   <= '0;
						state_q <= S_NLD;
					end
				end
				S_NLD: begin
					num_q   <= (NUMW'(ns_abs) << 21) + NUMW'(root_q >> 1);
					neg_q   <= ns_cur[NSW-1];
					rem_q   <= '0;
					quo_q   <= '0;
					bit_q   <= BW'(NUMW);
					state_q <= S_NDIV;
				end
				S_NDIV: begin
					rem_q <= op_ge ? op_d : op_a;
					quo_q <= qf;
					num_q <= {num_q[NUMW-2:0], 1'b0};
					bit_q <= bit_q - BW'(1);
					if (bit_q == BW'(1)) begin
						case (idx_q)
							2'd0:    res_q.out_norm_x <= nsat;
							2'd1:    res_q.out_norm_y <= nsat;
							default: res_q.out_norm_z <= nsat;
						endcase
						if (idx_q != 2'd2) begin
							idx_q   <= idx_q + 2'd1;
							state_q <= S_NLD;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_OUT: begin
					seen_q <= 1'b0;
					cnt_q  <= '0;
					best_q <= '0;
					if (result.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: sv/dcs_check.sv
module dcs_check (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      in_last,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic                      out_empty,
	input logic [dcs_pkg::TIE_W-1:0] out_count,
	input logic signed [31:0]        out_depth
);
	import dcs_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while a result waits");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("input ready straight after a closing word");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_empty |-> (out_count == '0) && (out_depth == '0))
		else $error("empty result carries data");

	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_empty |-> (out_count != '0))
		else $error("result with zero count");

endmodule

bind deepest_contact_select_core dcs_check u_dcs_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (points.valid),
	.in_ready  (points.ready),
	.in_last   (points.data.last),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_empty (result.data.empty_error),
	.out_count (result.data.tie_count),
	.out_depth (result.data.best_depth)
);

// File: tb/sv/tb_deepest_contact_select_core.sv
`timescale 1ns / 1ps

module tb_deepest_contact_select_core;
	import dcs_pkg::*;

	localparam int CLOSE_CYCLES = 200;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               tol_we = 1'b0;
	logic [TOL_W-1:0]   tol_data = '0;

	dcs_pts_if points();
	dcs_res_if result();

	deepest_contact_select_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.tol_we(tol_we),
		.tol_data(tol_data),
		.points(points.sink),
		.result(result.source)
	);

	always #5 clk = ~clk;

	// Model of the selection state.
	logic [15:0]        tol;
	logic signed [63:0] best;
	logic signed [63:0] psum [3];
	logic signed [63:0] nsum [3];
	int unsigned        ties;
	bit                 seen;

	res_word_t          pending_results [$];
	int                 mismatches = 0;
	int                 results_seen = 0;
	int                 sets_sent = 0;
	int                 words_sent = 0;
	bit                 stim_done = 1'b0;

	function automatic logic signed [63:0] round_div(logic signed [63:0] n, longint unsigned d);
		longint unsigned a;
		longint unsigned q;
		a = n < 0 ? -n : n;
		q = (a + d / 2) / d;
		return n < 0 ? -$signed(q) : $signed(q);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	task automatic clear_set();
		best = 0;
		ties = 0;
		seen = 1'b0;
		for (int i = 0; i < 3; i++) begin
			psum[i] = 0;
			nsum[i] = 0;
		end
	endtask

	task automatic absorb_word(input pts_word_t w);
		logic signed [63:0] d;
		logic signed [63:0] p [3];
		logic signed [63:0] n [3];
		res_word_t          r;
		longint unsigned    l2;
		longint unsigned    m;
		logic signed [63:0] c;
		if (!w.no_point) begin
			d = 64'(w.depth);
			p[0] = 64'(w.pos_x);  p[1] = 64'(w.pos_y);  p[2] = 64'(w.pos_z);
			n[0] = 64'(w.norm_x); n[1] = 64'(w.norm_y); n[2] = 64'(w.norm_z);
			if (!seen || d - best > longint'(tol)) begin
				best = d;
				for (int i = 0; i < 3; i++) begin
					psum[i] = p[i];
					nsum[i] = n[i];
				end
				ties = 1;
				seen = 1'b1;
			end else if (best - d <= longint'(tol)) begin
				if (ties < 256) begin
					for (int i = 0; i < 3; i++) begin
						psum[i] += p[i];
						nsum[i] += n[i];
					end
					ties++;
				end
			end
		end
		if (!w.last) return;
		r = '0;
		if (!seen) begin
			r.empty_error = 1'b1;
		end else begin
			r.best_depth = best[31:0];
			r.out_pos_x = 32'(round_div(psum[0], ties));
			r.out_pos_y = 32'(round_div(psum[1], ties));
			r.out_pos_z = 32'(round_div(psum[2], ties));
			if (ties <= 1) begin
				r.out_norm_x = nsum[0][15:0];
				r.out_norm_y = nsum[1][15:0];
				r.out_norm_z = nsum[2][15:0];
			end else if (nsum[0] == 0 && nsum[1] == 0 && nsum[2] == 0) begin
				r.out_norm_x = 16'(ONE_Q14);
			end else begin
				l2 = 0;
				for (int i = 0; i < 3; i++) l2 += nsum[i] * nsum[i];
				m = int_sqrt(l2 << 14);
				for (int i = 0; i < 3; i++) begin
					c = round_div(nsum[i] * 64'sd2097152, m);
					if (c > 32767) c = 32767;
					if (c < -32768) c = -32768;
					if (i == 0) r.out_norm_x = c[15:0];
					else if (i == 1) r.out_norm_y = c[15:0];
					else r.out_norm_z = c[15:0];
				end
			end
			r.tie_count = ties[TIE_W-1:0];
		end
		pending_results.push_back(r);
		clear_set();
	endtask

	// Sender: bursts of words with random gaps.
	int burst_left = 0;

	task automatic send_word(input pts_word_t w);
		if (burst_left == 0) begin
			points.valid <= 1'b0;
			repeat ($urandom_range(0, 4) * $urandom_range(0, 1)) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		points.valid <= 1'b1;
		points.data  <= w;
		@(posedge clk);
		while (!points.ready) @(posedge clk);
		absorb_word(w);
		words_sent++;
		if (w.last) sets_sent++;
		burst_left--;
		@(negedge clk);
	endtask

	task automatic write_tolerance(input logic [15:0] v);
		points.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (CLOSE_CYCLES) @(negedge clk);
		tol_we   <= 1'b1;
		tol_data <= v;
		@(negedge clk);
		tol_we <= 1'b0;
		tol = v;
	endtask

	function automatic pts_word_t make_point(logic signed [31:0] d, bit last, bit np);
		pts_word_t w;
		w.depth  = d;
		w.pos_x  = $urandom;
		w.pos_y  = $urandom;
		w.pos_z  = $urandom;
		w.norm_x = 16'($urandom);
		w.norm_y = 16'($urandom);
		w.norm_z = 16'($urandom);
		if ($urandom_range(0, 2) == 0) begin
			w.norm_x = 16'($signed(16'($urandom_range(0, 32767))) - 16384);
			w.norm_y = 16'($signed(16'($urandom_range(0, 32767))) - 16384);
			w.norm_z = 16'($signed(16'($urandom_range(0, 32767))) - 16384);
		end
		w.last     = last;
		w.no_point = np;
		return w;
	endfunction

	typedef struct {
		pts_word_t  w;
		bit         fixed;
		res_word_t  want;
	} stim_row_t;

	stim_row_t  directed [$];

	task automatic add_row(input pts_word_t w, input bit fixed, input res_word_t want);
		stim_row_t s;
		s.w = w;
		s.fixed = fixed;
		s.want = want;
		directed.push_back(s);
	endtask

	task automatic build_table();
		pts_word_t w;
		res_word_t r;
		// Empty set straight after reset.
		w = '0; w.last = 1; w.no_point = 1;
		r = '0; r.empty_error = 1;
		add_row(w, 1, r);
		// Single point at the extremes passes through unchanged.
		w = '0;
		w.depth = 32'h7fffffff; w.pos_x = 32'h80000000; w.pos_y = 32'h7fffffff;
		w.pos_z = 32'hffffffff; w.norm_x = 16'h8000; w.norm_y = 16'h7fff;
		w.norm_z = 16'hffff; w.last = 1;
		r = '0;
		r.best_depth = 32'h7fffffff; r.out_pos_x = 32'h80000000;
		r.out_pos_y = 32'h7fffffff; r.out_pos_z = 32'hffffffff;
		r.out_norm_x = 16'h8000; r.out_norm_y = 16'h7fff; r.out_norm_z = 16'hffff;
		r.tie_count = 1;
		add_row(w, 1, r);
		// Idle word, then a tie with opposite normals that sum to zero.
		w = '0; w.no_point = 1;
		add_row(w, 0, r);
		w = '0; w.depth = 32'h80000000; w.pos_x = 3; w.norm_y = 16'sd5000;
		add_row(w, 0, r);
		w = '0; w.depth = 32'h80000001; w.pos_x = 4; w.norm_y = -16'sd5000;
		add_row(w, 0, r);
		w = '0; w.last = 1; w.no_point = 1;
		r = '0; r.best_depth = 32'h80000001; r.out_pos_x = 4; r.out_norm_y = -16'sd5000;
		r.tie_count = 1;
		add_row(w, 0, r);
		// Deeper restart, shallower ignored, tie averaged and normalised.
		add_row(make_point(100, 0, 0), 0, r);
		add_row(make_point(50, 0, 0), 0, r);
		add_row(make_point(200, 0, 0), 0, r);
		add_row(make_point(-100, 0, 0), 0, r);
		add_row(make_point(201, 0, 0), 0, r);
		add_row(make_point(200, 1, 0), 0, r);
		w = make_point(-5, 0, 0); w.norm_x = 16'h7fff; w.norm_y = 16'h7fff; w.norm_z = 16'h7fff;
		add_row(w, 0, r);
		w.last = 1; w.pos_x = -w.pos_x;
		add_row(w, 0, r);
		w = make_point(7, 0, 0); w.norm_x = 16'h8000; w.norm_y = 0; w.norm_z = 0;
		add_row(w, 0, r);
		w.last = 1; w.depth = 8;
		add_row(w, 0, r);
	endtask

	task automatic random_set(input int depth_spread, input int npts);
		logic signed [31:0] base;
		pts_word_t          w;
		base = $urandom;
		for (int k = 0; k < npts; k++) begin
			case ($urandom_range(0, 9))
				0: w = make_point($urandom, 0, 0);
				1: w = make_point(base, 0, 1);
				default: w = make_point(base + $signed($urandom_range(0, 2 * depth_spread))
					- depth_spread, 0, 0);
			endcase
			w.last = (k == npts - 1);
			if (w.last && $urandom_range(0, 7) == 0) w.no_point = 1;
			send_word(w);
		end
	endtask

	task automatic tie_cap_set();
		pts_word_t w;
		for (int k = 0; k < 300; k++) begin
			w = make_point(1000 + (k % 2), k == 299, 0);
			send_word(w);
		end
	endtask

	task automatic random_phase(input int words);
		int start;
		int spread;
		start = words_sent;
		while (words_sent - start < words) begin
			spread = $urandom_range(0, 1) ? int'(tol) + 2 : $urandom_range(0, 70000);
			random_set(spread, $urandom_range(1, $urandom_range(0, 3) == 0 ? 40 : 6));
		end
	endtask

	initial begin
		points.valid = 1'b0;
		points.data  = '0;
		clear_set();
		tol = 1;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		build_table();
		foreach (directed[i]) begin
			if (directed[i].fixed) begin
				send_word(directed[i].w);
				pending_results[pending_results.size() - 1] = directed[i].want;
			end else begin
				send_word(directed[i].w);
			end
		end
		write_tolerance(16'hffff);
		random_phase(280);
		tie_cap_set();
		write_tolerance(16'h0000);
		random_phase(280);
		write_tolerance(16'($urandom));
		random_phase(280);
		write_tolerance(16'd1);
		random_phase(280);
		points.valid <= 1'b0;
		stim_done = 1'b1;
	end

	// Receiver stalls on a repeating pattern of its own, randomly relaxed, with regular stall-free stretches.
	int unsigned stall_phase = 0;

	always @(negedge clk) begin
		stall_phase <= stall_phase + 1;
		if (!arst_n) result.ready <= 1'b0;
		else if (stall_phase[9]) result.ready <= 1'b1;
		else result.ready <= (stall_phase % 7 < 4) || ($urandom_range(0, 3) == 0);
	end

	always @(posedge clk) begin
		res_word_t exp_r;
		if (arst_n && result.valid && result.ready) begin
			results_seen++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("Unexpected result word %p", result.data);
			end else begin
				exp_r = pending_results.pop_front();
				if (result.data !== exp_r) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %p, got %p", exp_r, result.data);
				end
			end
		end
	end

	initial begin
		wait (stim_done);
		while (pending_results.size() != 0) @(posedge clk);
		repeat (CLOSE_CYCLES) @(posedge clk);
		$display("Sent %0d words in %0d sets; %0d results checked, %0d mismatches.",
			words_sent, sets_sent, results_seen, mismatches);
		$display("Tolerances used: reset value, 0, 65535, a random value and 1.");
		if (mismatches == 0 && pending_results.size() == 0) begin
			$display("** deepest_contact_select_core: PASSED **");
		end else begin
			$display("** deepest_contact_select_core: FAILED **");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("** deepest_contact_select_core: FAILED **");
		$finish;
	end

endmodule

// File: sim.f
sv/dcs_pkg.sv
sv/dcs_if.sv
sv/deepest_contact_select_core.sv
sv/dcs_check.sv
tb/sv/tb_deepest_contact_select_core.sv
